// ----- src/ccf_pkg.sv -----
// ccf_pkg: shared widths, beat types and the front-end bundle for the circumcircle core
// no dependencies; used by every module in src
package ccf_pkg;

	localparam int COORD_BITS    = 16;
	localparam int FRAC_BITS_DEF = 8;
	localparam int OUT_BITS      = 40;

	// front-end arithmetic widths
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * COORD_BITS + 1;
	localparam int PA_W   = 2 * COORD_BITS + 1;
	localparam int A_W    = 2 * COORD_BITS + 3;
	localparam int PN_W   = SQ_W + DIFF_W;
	localparam int N_W    = 3 * COORD_BITS + 4;
	localparam int DEN_W  = A_W + 1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by;
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
	} pts_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] center_x;
		logic signed [OUT_BITS-1:0] center_y;
		logic        [OUT_BITS-1:0] radius;
		logic                       collinear;
		logic                       saturated;
	} circ_t;

	// numerators, denominator and side data handed from the front end to the dividers
	typedef struct packed {
		logic        [N_W-1:0]        nx_mag;
		logic        [N_W-1:0]        ny_mag;
		logic        [DEN_W-1:0]      den_mag;
		logic                         neg_x;
		logic                         neg_y;
		logic                         coll;
		logic signed [COORD_BITS-1:0] x1;
		logic signed [COORD_BITS-1:0] y1;
	} front_t;

endpackage

// ----- src/ccf_front.sv -----
// ccf_front: six-stage front end, determinant and center numerators as magnitudes and signs
// depends on ccf_pkg
module ccf_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  ccf_pkg::pts_t   pts,
	output logic            vld_o,
	output ccf_pkg::front_t fe
);

	localparam int C      = ccf_pkg::COORD_BITS;
	localparam int DIFF_W = ccf_pkg::DIFF_W;
	localparam int SQ_W   = ccf_pkg::SQ_W;
	localparam int PA_W   = ccf_pkg::PA_W;
	localparam int A_W    = ccf_pkg::A_W;
	localparam int PN_W   = ccf_pkg::PN_W;
	localparam int N_W    = ccf_pkg::N_W;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	ccf_pkg::pts_t pts_s1, pts_s2;
	logic signed [DIFF_W-1:0] y23_s2, y31_s2, y12_s2, x32_s2, x13_s2, x21_s2;
	logic signed [2*C-1:0]    xa2_s2, ya2_s2, xb2_s2, yb2_s2, xp2_s2, yp2_s2;

	logic signed [C-1:0]      x1_s3, y1_s3;
	logic signed [DIFF_W-1:0] y23_s3, y31_s3, y12_s3, x32_s3, x13_s3, x21_s3;
	logic signed [SQ_W-1:0]   sa_s3, sb_s3, sp_s3;
	logic signed [PA_W-1:0]   pa0_s3, pa1_s3, pa2_s3, pa3_s3;

	logic signed [C-1:0]      x1_s4, y1_s4;
	logic signed [A_W-1:0]    a_s4;
	logic signed [PN_W-1:0]   px0_s4, px1_s4, px2_s4, py0_s4, py1_s4, py2_s4;

	logic signed [C-1:0]      x1_s5, y1_s5;
	logic signed [N_W-1:0]    nx_s5, ny_s5;
	logic        [A_W-1:0]    amag_s5;
	logic                     aneg_s5, coll_s5;

	ccf_pkg::front_t fe_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: input beat
			pts_s1 <= pts;

			// s2: coordinate differences and squares
			pts_s2 <= pts_s1;
			y23_s2 <= DIFF_W'(pts_s1.by) - DIFF_W'(pts_s1.py);
			y31_s2 <= DIFF_W'(pts_s1.py) - DIFF_W'(pts_s1.ay);
			y12_s2 <= DIFF_W'(pts_s1.ay) - DIFF_W'(pts_s1.by);
			x32_s2 <= DIFF_W'(pts_s1.px) - DIFF_W'(pts_s1.bx);
			x13_s2 <= DIFF_W'(pts_s1.ax) - DIFF_W'(pts_s1.px);
			x21_s2 <= DIFF_W'(pts_s1.bx) - DIFF_W'(pts_s1.ax);
			xa2_s2 <= (2*C)'(pts_s1.ax) * (2*C)'(pts_s1.ax);
			ya2_s2 <= (2*C)'(pts_s1.ay) * (2*C)'(pts_s1.ay);
			xb2_s2 <= (2*C)'(pts_s1.bx) * (2*C)'(pts_s1.bx);
			yb2_s2 <= (2*C)'(pts_s1.by) * (2*C)'(pts_s1.by);
			xp2_s2 <= (2*C)'(pts_s1.px) * (2*C)'(pts_s1.px);
			yp2_s2 <= (2*C)'(pts_s1.py) * (2*C)'(pts_s1.py);

			// s3: squared norms and determinant products
			x1_s3  <= pts_s2.ax;
			y1_s3  <= pts_s2.ay;
			y23_s3 <= y23_s2;
			y31_s3 <= y31_s2;
			y12_s3 <= y12_s2;
			x32_s3 <= x32_s2;
			x13_s3 <= x13_s2;
			x21_s3 <= x21_s2;
			sa_s3  <= SQ_W'(xa2_s2) + SQ_W'(ya2_s2);
			sb_s3  <= SQ_W'(xb2_s2) + SQ_W'(yb2_s2);
			sp_s3  <= SQ_W'(xp2_s2) + SQ_W'(yp2_s2);
			pa0_s3 <= PA_W'(pts_s2.ax) * PA_W'(y23_s2);
			pa1_s3 <= PA_W'(pts_s2.ay) * PA_W'(x32_s2);
			pa2_s3 <= PA_W'(pts_s2.bx) * PA_W'(pts_s2.py);
			pa3_s3 <= PA_W'(pts_s2.px) * PA_W'(pts_s2.by);

			// s4: determinant sum and numerator products
			x1_s4  <= x1_s3;
			y1_s4  <= y1_s3;
			a_s4   <= A_W'(pa0_s3) + A_W'(pa1_s3) + A_W'(pa2_s3) - A_W'(pa3_s3);
			px0_s4 <= PN_W'(sa_s3) * PN_W'(y23_s3);
			px1_s4 <= PN_W'(sb_s3) * PN_W'(y31_s3);
			px2_s4 <= PN_W'(sp_s3) * PN_W'(y12_s3);
			py0_s4 <= PN_W'(sa_s3) * PN_W'(x32_s3);
			py1_s4 <= PN_W'(sb_s3) * PN_W'(x13_s3);
			py2_s4 <= PN_W'(sp_s3) * PN_W'(x21_s3);

			// s5: numerator sums, determinant magnitude
			x1_s5   <= x1_s4;
			y1_s5   <= y1_s4;
			nx_s5   <= N_W'(px0_s4) + N_W'(px1_s4) + N_W'(px2_s4);
			ny_s5   <= N_W'(py0_s4) + N_W'(py1_s4) + N_W'(py2_s4);
			amag_s5 <= a_s4[A_W-1] ? (~a_s4 + 1'b1) : a_s4;
			aneg_s5 <= a_s4[A_W-1];
			coll_s5 <= (a_s4 == '0);

			// s6: numerator magnitudes, quotient signs, denominator is twice the determinant
			fe_s6.nx_mag  <= nx_s5[N_W-1] ? (~nx_s5 + 1'b1) : nx_s5;
			fe_s6.ny_mag  <= ny_s5[N_W-1] ? (~ny_s5 + 1'b1) : ny_s5;
			fe_s6.den_mag <= {amag_s5, 1'b0};
			fe_s6.neg_x   <= nx_s5[N_W-1] ^ aneg_s5;
			fe_s6.neg_y   <= ny_s5[N_W-1] ^ aneg_s5;
			fe_s6.coll    <= coll_s5;
			fe_s6.x1      <= x1_s5;
			fe_s6.y1      <= y1_s5;
		end
	end

	assign vld_o = vld_s6;
	assign fe    = fe_s6;

endmodule

// ----- src/ccf_div.sv -----
// ccf_div: pipelined restoring divider, one quotient bit per stage, signed saturating result
// depends on ccf_pkg
module ccf_div #(
	parameter int FRAC_BITS = ccf_pkg::FRAC_BITS_DEF,
	parameter int TAG_W     = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vld_i,
	input  logic [ccf_pkg::N_W-1:0]           num,
	input  logic [ccf_pkg::DEN_W-1:0]         den,
	input  logic                              neg,
	input  logic [TAG_W-1:0]                  tag_i,
	output logic                              vld_o,
	output logic signed [ccf_pkg::OUT_BITS-1:0] res,
	output logic                              sat,
	output logic [TAG_W-1:0]                  tag_o
);

	localparam int NW = ccf_pkg::N_W;
	localparam int DW = ccf_pkg::DEN_W;
	localparam int QB = ccf_pkg::OUT_BITS;
	localparam int HW = NW + FRAC_BITS;
	localparam int EW = HW + QB;

	logic [EW-1:0] ext;
	logic [HW-1:0] hi;
	logic          ovf;

	logic          vld_s [0:QB];
	logic [DW-1:0] rem_s [0:QB];
	logic [QB-1:0] lo_s  [0:QB];
	logic [QB-1:0] quo_s [0:QB];
	logic [DW-1:0] den_s [0:QB];
	logic          neg_s [0:QB];
	logic          ovf_s [0:QB];
	logic [TAG_W-1:0] tag_s [0:QB];

	logic                 vld_sn;
	logic signed [QB-1:0] res_sn;
	logic                 sat_sn;
	logic [TAG_W-1:0]     tag_sn;

	logic [QB-1:0] q_fin;
	logic [QB-1:0] val_fin;
	logic          sat_fin;

	// scaled numerator; the part above the quotient bits decides overflow up front
	assign ext = EW'(num) << FRAC_BITS;
	assign hi  = ext[EW-1:QB];
	assign ovf = (hi >= HW'(den));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ovf ? '0 : hi[DW-1:0];
			lo_s[0]  <= ext[QB-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
			ovf_s[0] <= ovf;
			tag_s[0] <= tag_i;
		end
	end

	genvar k;
	for (k = 0; k < QB; k++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		assign trial = {rem_s[k], lo_s[k][QB-1-k]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = (trial >= {1'b0, den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				quo_s[k+1] <= {quo_s[k][QB-2:0], ge};
				lo_s[k+1]  <= lo_s[k];
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	// sign and clip to the signed output range
	always_comb begin
		q_fin = quo_s[QB];
		if (!neg_s[QB]) begin
			sat_fin = ovf_s[QB] | q_fin[QB-1];
			val_fin = sat_fin ? {1'b0, {(QB-1){1'b1}}} : q_fin;
		end else begin
			sat_fin = ovf_s[QB] | (q_fin[QB-1] & (|q_fin[QB-2:0]));
			val_fin = sat_fin ? {1'b1, {(QB-1){1'b0}}} : (~q_fin + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (en) begin
			vld_sn <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_sn <= val_fin;
			sat_sn <= sat_fin;
			tag_sn <= tag_s[QB];
		end
	end

	assign vld_o = vld_sn;
	assign res   = res_sn;
	assign sat   = sat_sn;
	assign tag_o = tag_sn;

endmodule

// ----- src/ccf_root.sv -----
// ccf_root: radius pipeline, offsets from point one, split squares, bit-pair square root
// depends on ccf_pkg
module ccf_root #(
	parameter int FRAC_BITS = ccf_pkg::FRAC_BITS_DEF,
	parameter int TAG_W     = 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  vld_i,
	input  logic signed [ccf_pkg::OUT_BITS-1:0]   cx,
	input  logic signed [ccf_pkg::OUT_BITS-1:0]   cy,
	input  logic signed [ccf_pkg::COORD_BITS-1:0] x1,
	input  logic signed [ccf_pkg::COORD_BITS-1:0] y1,
	input  logic [TAG_W-1:0]                      tag_i,
	output logic                                  vld_o,
	output logic [ccf_pkg::OUT_BITS-1:0]          radius,
	output logic                                  sat,
	output logic [TAG_W-1:0]                      tag_o
);

	localparam int OW  = ccf_pkg::OUT_BITS;
	localparam int DXW = OW + 1;
	localparam int LW  = (DXW + 1) / 2;
	localparam int HDW = DXW - LW;
	localparam int SQW = 2 * DXW;
	localparam int SW  = SQW + 1;
	localparam int RW  = (SW + 1) / 2;
	localparam int VW  = 2 * RW;
	localparam int RMW = RW + 2;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3, tag_s4;

	logic signed [DXW-1:0] dx_s1, dy_s1;
	logic        [DXW-1:0] dxm_s2, dym_s2;
	logic [2*HDW-1:0]  xhh_s3, yhh_s3;
	logic [HDW+LW-1:0] xhl_s3, yhl_s3;
	logic [2*LW-1:0]   xll_s3, yll_s3;
	logic [SQW-1:0]    sqx_s4, sqy_s4;

	// square root stages; index 0 holds the padded sum of squares
	logic           vld_s  [0:RW];
	logic [VW-1:0]  val_s  [0:RW];
	logic [RMW-1:0] rem_s  [0:RW];
	logic [RW-1:0]  rt_s   [0:RW];
	logic [TAG_W-1:0] tag_s [0:RW];

	logic          vld_sn;
	logic [OW-1:0] rad_sn;
	logic          sat_sn;
	logic [TAG_W-1:0] tag_sn;

	logic rsat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1   <= vld_i;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_s[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: offsets of the center from point one, both in fixed point
			dx_s1  <= DXW'(cx) - (DXW'(x1) <<< FRAC_BITS);
			dy_s1  <= DXW'(cy) - (DXW'(y1) <<< FRAC_BITS);
			tag_s1 <= tag_i;

			// s2: magnitudes
			dxm_s2 <= dx_s1[DXW-1] ? (~dx_s1 + 1'b1) : dx_s1;
			dym_s2 <= dy_s1[DXW-1] ? (~dy_s1 + 1'b1) : dy_s1;
			tag_s2 <= tag_s1;

			// s3: partial products of the split squares
			xhh_s3 <= (2*HDW)'(dxm_s2[DXW-1:LW]) * (2*HDW)'(dxm_s2[DXW-1:LW]);
			xhl_s3 <= (HDW+LW)'(dxm_s2[DXW-1:LW]) * (HDW+LW)'(dxm_s2[LW-1:0]);
			xll_s3 <= (2*LW)'(dxm_s2[LW-1:0]) * (2*LW)'(dxm_s2[LW-1:0]);
			yhh_s3 <= (2*HDW)'(dym_s2[DXW-1:LW]) * (2*HDW)'(dym_s2[DXW-1:LW]);
			yhl_s3 <= (HDW+LW)'(dym_s2[DXW-1:LW]) * (HDW+LW)'(dym_s2[LW-1:0]);
			yll_s3 <= (2*LW)'(dym_s2[LW-1:0]) * (2*LW)'(dym_s2[LW-1:0]);
			tag_s3 <= tag_s2;

			// s4: recombine the squares
			sqx_s4 <= (SQW'(xhh_s3) << (2*LW)) + (SQW'(xhl_s3) << (LW+1)) + SQW'(xll_s3);
			sqy_s4 <= (SQW'(yhh_s3) << (2*LW)) + (SQW'(yhl_s3) << (LW+1)) + SQW'(yll_s3);
			tag_s4 <= tag_s3;

			// root stage 0: sum of squares
			val_s[0] <= VW'(SW'(sqx_s4) + SW'(sqy_s4));
			rem_s[0] <= '0;
			rt_s[0]  <= '0;
			tag_s[0] <= tag_s4;
		end
	end

	genvar k;
	for (k = 0; k < RW; k++) begin : g_bit
		logic [RMW+1:0] cur;
		logic [RMW+1:0] trial;
		logic [RMW+1:0] diff;
		logic           ge;

		assign cur   = {rem_s[k], val_s[k][VW-1:VW-2]};
		assign trial = (RMW+2)'({rt_s[k], 2'b01});
		assign diff  = cur - trial;
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[RMW-1:0] : cur[RMW-1:0];
				rt_s[k+1]  <= {rt_s[k][RW-2:0], ge};
				val_s[k+1] <= val_s[k] << 2;
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign rsat = |rt_s[RW][RW-1:OW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (en) begin
			vld_sn <= vld_s[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_sn <= rsat ? {OW{1'b1}} : rt_s[RW][OW-1:0];
			sat_sn <= rsat;
			tag_sn <= tag_s[RW];
		end
	end

	assign vld_o  = vld_sn;
	assign radius = rad_sn;
	assign sat    = sat_sn;
	assign tag_o  = tag_sn;

endmodule

// ----- src/circumcircle_from_three_points_core.sv -----
// circumcircle_from_three_points_core: top level, fixed-point circumcircle of three points
// depends on ccf_pkg, ccf_front, ccf_div, ccf_root
//
//   channel | valid      | stall      | payload           | beat
//   points  | pts_valid  | pts_stall  | pts  (pts_t)      | three integer points
//   circle  | circ_valid | circ_stall | circ (circ_t)     | center, radius, flags
//
// one beat enters per cycle while pts_stall is low; the path is 6 front-end stages,
// 42 divider stages, 48 radius stages and the output register
// the two 40-step divider lanes and the 42-step square root set the depth
// the whole pipeline moves on one enable, held only while the skid register is full
// a result waiting on circ_stall does not block input: the next one lands in the skid
// reset clears all valid bits; payload registers are left as they are

module circumcircle_from_three_points_core #(
	parameter int FRAC_BITS = ccf_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pts_valid,
	output logic           pts_stall,
	input  ccf_pkg::pts_t  pts,
	output logic           circ_valid,
	input  logic           circ_stall,
	output ccf_pkg::circ_t circ
);

	localparam int C   = ccf_pkg::COORD_BITS;
	localparam int OW  = ccf_pkg::OUT_BITS;
	localparam int RTW = 2 * OW + 2;

	// pipeline enable: stop only when the skid register holds a beat
	logic en;

	// front end to divider lanes
	logic            fe_vld;
	ccf_pkg::front_t fe;

	// divider lanes
	logic                 dx_vld, dy_vld;
	logic signed [OW-1:0] cx, cy;
	logic                 cx_sat, cy_sat;
	logic [C-1:0]         x_tag;
	logic [C:0]           y_tag;

	// radius pipeline; its tag carries center, collinear and center clip flag
	logic          rt_vld;
	logic [OW-1:0] rt_rad;
	logic          rt_sat;
	logic [RTW-1:0] rt_tag_i, rt_tag_o;

	// finished beat
	logic signed [OW-1:0] fin_cx, fin_cy;
	logic                 fin_coll, fin_csat;
	ccf_pkg::circ_t       fin;

	// output register and skid
	ccf_pkg::circ_t circ_q, skid_q;
	logic           out_vld_q, skid_vld_q;
	logic           push, pop;

	assign en        = !skid_vld_q;
	assign pts_stall = skid_vld_q;

	ccf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (pts_valid),
		.pts    (pts),
		.vld_o  (fe_vld),
		.fe     (fe)
	);

	ccf_div #(
		.FRAC_BITS (FRAC_BITS),
		.TAG_W     (C)
	) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (fe_vld),
		.num    (fe.nx_mag),
		.den    (fe.den_mag),
		.neg    (fe.neg_x),
		.tag_i  (fe.x1),
		.vld_o  (dx_vld),
		.res    (cx),
		.sat    (cx_sat),
		.tag_o  (x_tag)
	);

	ccf_div #(
		.FRAC_BITS (FRAC_BITS),
		.TAG_W     (C + 1)
	) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (fe_vld),
		.num    (fe.ny_mag),
		.den    (fe.den_mag),
		.neg    (fe.neg_y),
		.tag_i  ({fe.y1, fe.coll}),
		.vld_o  (dy_vld),
		.res    (cy),
		.sat    (cy_sat),
		.tag_o  (y_tag)
	);

	// radius is measured from the already clipped center
	assign rt_tag_i = {cx, cy, y_tag[0], cx_sat | cy_sat};

	ccf_root #(
		.FRAC_BITS (FRAC_BITS),
		.TAG_W     (RTW)
	) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (dx_vld & dy_vld),
		.cx     (cx),
		.cy     (cy),
		.x1     (x_tag),
		.y1     (y_tag[C:1]),
		.tag_i  (rt_tag_i),
		.vld_o  (rt_vld),
		.radius (rt_rad),
		.sat    (rt_sat),
		.tag_o  (rt_tag_o)
	);

	// collinear points give an all-zero beat with only the collinear flag set
	assign fin_cx   = rt_tag_o[RTW-1:OW+2];
	assign fin_cy   = rt_tag_o[OW+1:2];
	assign fin_coll = rt_tag_o[1];
	assign fin_csat = rt_tag_o[0];

	always_comb begin
		fin.center_x  = fin_coll ? '0 : fin_cx;
		fin.center_y  = fin_coll ? '0 : fin_cy;
		fin.radius    = fin_coll ? '0 : rt_rad;
		fin.collinear = fin_coll;
		fin.saturated = !fin_coll && (fin_csat || rt_sat);
	end

	assign push = en && rt_vld;
	assign pop  = out_vld_q && !circ_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				circ_q <= skid_q;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_q <= fin;
			end else begin
				circ_q <= fin;
			end
		end
	end

	assign circ_valid = out_vld_q;
	assign circ       = circ_q;

endmodule

// ----- src/ccf_chk.sv -----
// ccf_chk: port-level checks for the circumcircle core, bound to the top level
// depends on ccf_pkg and circumcircle_from_three_points_core
module ccf_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           pts_stall,
	input logic           circ_valid,
	input logic           circ_stall,
	input ccf_pkg::circ_t circ
);

	// a stalled result beat stays and holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		circ_valid && circ_stall |=> circ_valid && $stable(circ))
		else $error("result beat changed while stalled");

	// input back-pressure only follows a result that was held back
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pts_stall) |-> $past(circ_valid && circ_stall))
		else $error("input stalled without a held result");

	// collinear beats carry no geometry
	a_coll_zero: assert property (@(posedge clk) disable iff (!arst_n)
		circ_valid && circ.collinear |->
		circ.center_x == '0 && circ.center_y == '0 && circ.radius == '0 && !circ.saturated)
		else $error("collinear beat with nonzero fields");

	// a clipped center sits exactly on a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		circ_valid && circ.saturated && circ.radius != '1 |->
		circ.center_x == {1'b0, {(ccf_pkg::OUT_BITS-1){1'b1}}} ||
		circ.center_x == {1'b1, {(ccf_pkg::OUT_BITS-1){1'b0}}} ||
		circ.center_y == {1'b0, {(ccf_pkg::OUT_BITS-1){1'b1}}} ||
		circ.center_y == {1'b1, {(ccf_pkg::OUT_BITS-1){1'b0}}})
		else $error("saturated beat with no field at a limit");

endmodule

bind circumcircle_from_three_points_core ccf_chk u_ccf_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.pts_stall  (pts_stall),
	.circ_valid (circ_valid),
	.circ_stall (circ_stall),
	.circ       (circ)
);
